// File: rtl/rsd_pkg.sv
// Shared types and constants for the radial stick deadzone block.
package rsd_pkg;

  localparam int DZ_W = 15;
  localparam logic [DZ_W-1:0] DZ_RESET = 15'd3277;

  typedef struct packed {
    logic en;
    logic vld;
  } rsd_ctl_t;

endpackage

// File: rtl/rsd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rsd_sqrt import rsd_pkg::*; #(
  parameter int R_W = 16,
  parameter int P_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  rsd_ctl_t         ctl,
  input  logic [2*R_W-1:0] sq,
  input  logic [P_W-1:0]   pay,
  output logic             out_vld,
  output logic [R_W-1:0]   root,
  output logic [P_W-1:0]   out_pay
);

  localparam int SW = 2 * R_W;

  logic [SW-1:0]  rem [1:R_W-1];
  logic [R_W-1:0] res [1:R_W];
  logic [P_W-1:0] p   [1:R_W];
  logic           v   [1:R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    localparam int J = R_W - 1 - k;
    logic [SW-1:0]  remi;
    logic [R_W-1:0] resi;
    logic [P_W-1:0] pi;
    logic           vi;
    logic [SW:0]    t;
    logic           fit;

    if (k == 0) begin : g_first
      assign remi = sq;
      assign resi = '0;
      assign pi   = pay;
      assign vi   = ctl.vld;
    end else begin : g_rest
      assign remi = rem[k];
      assign resi = res[k];
      assign pi   = p[k];
      assign vi   = v[k];
    end

    assign t   = ((SW+1)'(resi) << (J + 1)) + ((SW+1)'(1) << (2 * J));
    assign fit = {1'b0, remi} >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (ctl.en) begin
        v[k+1] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        res[k+1] <= fit ? (resi | (R_W'(1) << J)) : resi;
        p[k+1]   <= pi;
      end
    end

    if (k < R_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (ctl.en) begin
          rem[k+1] <= fit ? (remi - t[SW-1:0]) : remi;
        end
      end
    end
  end

  assign out_vld = v[R_W];
  assign root    = res[R_W];
  assign out_pay = p[R_W];

endmodule

// File: rtl/rsd_div.sv
// Pipelined restoring divider, one quotient bit per stage; needs num < den * 2^Q_W.
module rsd_div import rsd_pkg::*; #(
  parameter int D_W = 16,
  parameter int Q_W = 16,
  parameter int P_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rsd_ctl_t             ctl,
  input  logic [D_W+Q_W-1:0]   num,
  input  logic [D_W-1:0]       den,
  input  logic [P_W-1:0]       pay,
  output logic                 out_vld,
  output logic [Q_W-1:0]       quo,
  output logic [P_W-1:0]       out_pay
);

  localparam int W = D_W + Q_W;

  logic [W-1:0]   r [1:Q_W-1];
  logic [D_W-1:0] d [1:Q_W-1];
  logic [Q_W-1:0] q [1:Q_W];
  logic [P_W-1:0] p [1:Q_W];
  logic           v [1:Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic [W-1:0]   ri;
    logic [D_W-1:0] di;
    logic [Q_W-1:0] qi;
    logic [P_W-1:0] pi;
    logic           vi;
    logic [W-1:0]   dsh;
    logic           fit;

    if (k == 0) begin : g_first
      assign ri = num;
      assign di = den;
      assign qi = '0;
      assign pi = pay;
      assign vi = ctl.vld;
    end else begin : g_rest
      assign ri = r[k];
      assign di = d[k];
      assign qi = q[k];
      assign pi = p[k];
      assign vi = v[k];
    end

    assign dsh = W'(di) << B;
    assign fit = ri >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (ctl.en) begin
        v[k+1] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        q[k+1] <= fit ? (qi | (Q_W'(1) << B)) : qi;
        p[k+1] <= pi;
      end
    end

    if (k < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (ctl.en) begin
          r[k+1] <= fit ? (ri - dsh) : ri;
          d[k+1] <= di;
        end
      end
    end
  end

  assign out_vld = v[Q_W];
  assign quo     = q[Q_W];
  assign out_pay = p[Q_W];

endmodule

// File: rtl/radial_stick_deadzone_top.sv
// Scaled radial deadzone for one analog stick sample, fully pipelined.
//
//   channel | direction | handshake          | payload
//   dz      | in        | dz_we              | dz_wdata
//   in      | in        | in_valid/in_stall  | pad_present, stick_x, stick_y
//   out     | out       | out_valid/out_stall| out_x, out_y, in_deadzone, saturated
//
// One request per cycle while the output is not stalled; a sample passes capture,
// squares, sum, square root, scaling divider, products, x/y dividers and output.
// Synchronous reset clears valid bits and loads the deadzone with about 0.1.
// A stalled output holds the whole pipeline; in_stall follows it directly.
module radial_stick_deadzone_top import rsd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          dz_we,
  input  logic [DZ_W-1:0]               dz_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          pad_present,
  input  logic signed [SAMPLE_BITS-1:0] stick_x,
  input  logic signed [SAMPLE_BITS-1:0] stick_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_x,
  output logic signed [SAMPLE_BITS-1:0] out_y,
  output logic                          in_deadzone,
  output logic                          saturated
);

  localparam int F   = SAMPLE_BITS - 1;
  localparam int M_W = F + 1;
  localparam int S_W = 2 * F + 1;
  localparam int P_W = 3 * F + 2;

  logic     en;
  rsd_ctl_t ctl;

  logic [DZ_W-1:0]    dz;
  logic [M_W-1:0]     dzq;
  logic [2*M_W-1:0]   dzsq;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dz <= DZ_RESET;
    end else if (dz_we) begin
      dz <= dz_wdata;
    end
  end

  if (F >= DZ_W) begin : g_dz_up
    assign dzq = M_W'(dz) << (F - DZ_W);
  end else begin : g_dz_dn
    assign dzq = M_W'(dz >> (DZ_W - F));
  end

  always_ff @(posedge clk) begin
    dzsq <= (2*M_W)'(dzq) * (2*M_W)'(dzq);
  end

  // stage 1: input capture
  logic                          v1, p1;
  logic signed [SAMPLE_BITS-1:0] x1, y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= pad_present;
      x1 <= stick_x;
      y1 <= stick_y;
    end
  end

  // stage 2: squares and magnitudes
  logic signed [2*SAMPLE_BITS-1:0] xsq, ysq;
  logic                            v2, p2, sx2, sy2;
  logic [S_W-1:0]                  xx2, yy2;
  logic [M_W-1:0]                  ax2, ay2;

  assign xsq = x1 * x1;
  assign ysq = y1 * y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2  <= p1;
      sx2 <= x1[F];
      sy2 <= y1[F];
      xx2 <= xsq[S_W-1:0];
      yy2 <= ysq[S_W-1:0];
      ax2 <= x1[F] ? M_W'(-x1) : M_W'(x1);
      ay2 <= y1[F] ? M_W'(-y1) : M_W'(y1);
    end
  end

  // stage 3: sum of squares
  logic             v3, p3, sx3, sy3;
  logic [2*M_W-1:0] sum3;
  logic [M_W-1:0]   ax3, ay3;
  logic             dead3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3   <= p2;
      sx3  <= sx2;
      sy3  <= sy2;
      ax3  <= ax2;
      ay3  <= ay2;
      sum3 <= (2*M_W)'(xx2) + (2*M_W)'(yy2);
    end
  end

  assign dead3 = !p3 || (sum3 == '0) || (sum3 < dzsq);
  assign ctl   = '{en: en, vld: v3};

  // magnitude
  localparam int SQ_PW = 2 * M_W + 3;
  logic             vm;
  logic [M_W-1:0]   m;
  logic [SQ_PW-1:0] sq_pay_o;
  logic [M_W-1:0]   axm, aym;
  logic             sxm, sym, deadm;

  rsd_sqrt #(.R_W(M_W), .P_W(SQ_PW)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sq      (sum3),
    .pay     ({ax3, ay3, sx3, sy3, dead3}),
    .out_vld (vm),
    .root    (m),
    .out_pay (sq_pay_o)
  );

  assign {axm, aym, sxm, sym, deadm} = sq_pay_o;

  // scaled magnitude s = ((m - dz) << F) / (1.0 - dz)
  localparam int D1_PW = 3 * M_W + 3;
  rsd_ctl_t         ctl_m;
  logic [M_W-1:0]   dm, den1;
  logic [P_W-1:0]   num1;
  logic             vs;
  logic [S_W-1:0]   s;
  logic [D1_PW-1:0] d1_pay_o;
  logic [M_W-1:0]   ms, axs, ays;
  logic             sxs, sys, deads;

  assign ctl_m = '{en: en, vld: vm};
  assign dm    = m - dzq;
  assign num1  = deadm ? '0 : (P_W'(dm) << F);
  assign den1  = {1'b1, {F{1'b0}}} - dzq;

  rsd_div #(.D_W(M_W), .Q_W(S_W), .P_W(D1_PW)) u_div_s (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_m),
    .num     (num1),
    .den     (den1),
    .pay     ({m, axm, aym, sxm, sym, deadm}),
    .out_vld (vs),
    .quo     (s),
    .out_pay (d1_pay_o)
  );

  assign {ms, axs, ays, sxs, sys, deads} = d1_pay_o;

  // stage: component products
  logic           v6, sx6, sy6, dead6;
  logic [P_W-1:0] px6, py6;
  logic [M_W-1:0] m6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px6   <= P_W'(axs) * P_W'(s);
      py6   <= P_W'(ays) * P_W'(s);
      m6    <= ms;
      sx6   <= sxs;
      sy6   <= sys;
      dead6 <= deads;
    end
  end

  // component quotients, clipped early when they cannot fit
  rsd_ctl_t         ctl_6;
  logic [P_W-1:0]   mlim;
  logic             ovx, ovy;
  logic [2*M_W-1:0] numx, numy;
  logic             vq, vq_y;
  logic [M_W-1:0]   qx, qy;
  logic [3:0]       dx_pay_o;
  logic             sxq, syq, deadq, ovxq, ovyq;

  assign ctl_6 = '{en: en, vld: v6};
  assign mlim  = P_W'(m6) << M_W;
  assign ovx   = px6 >= mlim;
  assign ovy   = py6 >= mlim;
  assign numx  = ovx ? '0 : px6[2*M_W-1:0];
  assign numy  = ovy ? '0 : py6[2*M_W-1:0];

  rsd_div #(.D_W(M_W), .Q_W(M_W), .P_W(4)) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_6),
    .num     (numx),
    .den     (m6),
    .pay     ({sx6, sy6, dead6, ovx}),
    .out_vld (vq),
    .quo     (qx),
    .out_pay (dx_pay_o)
  );

  rsd_div #(.D_W(M_W), .Q_W(M_W), .P_W(1)) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_6),
    .num     (numy),
    .den     (m6),
    .pay     (ovy),
    .out_vld (vq_y),
    .quo     (qy),
    .out_pay (ovyq)
  );

  assign {sxq, syq, deadq, ovxq} = dx_pay_o;

  // saturation and output register
  logic [M_W-1:0] one_q;
  logic           bigx, bigy;
  logic [M_W-1:0] rx, ry;

  assign one_q = {1'b1, {F{1'b0}}};
  assign bigx  = ovxq || (sxq ? (qx > one_q) : qx[F]);
  assign bigy  = ovyq || (syq ? (qy > one_q) : qy[F]);
  assign rx    = bigx ? (sxq ? one_q : ~one_q) : (sxq ? (-qx) : qx);
  assign ry    = bigy ? (syq ? one_q : ~one_q) : (syq ? (-qy) : qy);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vq && vq_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x       <= deadq ? '0 : $signed(rx);
      out_y       <= deadq ? '0 : $signed(ry);
      in_deadzone <= deadq;
      saturated   <= !deadq && (bigx || bigy);
    end
  end

endmodule

// File: bench/radial_stick_deadzone_top_tb.sv
// Self-checking testbench for the radial stick deadzone block.
`timescale 1ns / 1ps

module radial_stick_deadzone_top_tb;
  import rsd_pkg::*;

  localparam int SB = 16;
  localparam int FB = SB - 1;
  localparam int LATENCY = 4 * SB + 4;
  localparam longint ONE_Q = 64'sd1 <<< FB;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [SB-1:0] ox;
    logic signed [SB-1:0] oy;
    logic dz_flag;
    logic sat;
  } stick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic dz_we = 1'b0;
  logic [DZ_W-1:0] dz_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic pad_present = 1'b0;
  logic signed [SB-1:0] stick_x = '0;
  logic signed [SB-1:0] stick_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] out_x;
  logic signed [SB-1:0] out_y;
  logic in_deadzone;
  logic saturated;

  logic [DZ_W-1:0] dz_shadow = DZ_RESET;
  stick_result_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_cfg = 0;

  radial_stick_deadzone_top #(.SAMPLE_BITS(SB)) u_top (
    .clk(clk), .rst(rst), .dz_we(dz_we), .dz_wdata(dz_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .pad_present(pad_present),
    .stick_x(stick_x), .stick_y(stick_y), .out_valid(out_valid),
    .out_stall(out_stall), .out_x(out_x), .out_y(out_y),
    .in_deadzone(in_deadzone), .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip_axis(longint v, longint unsigned s, longint unsigned m,
                                       ref logic sat);
    longint unsigned a;
    longint unsigned q;
    a = (v < 0) ? -v : v;
    q = (a * s) / m;
    if (v < 0) begin
      if (q > ONE_Q) begin
        sat = 1'b1;
        q = ONE_Q;
      end
      return -longint'(q);
    end
    if (q > ONE_Q - 1) begin
      sat = 1'b1;
      q = ONE_Q - 1;
    end
    return longint'(q);
  endfunction

  function automatic stick_result_t rescale_stick(logic pres, logic signed [SB-1:0] sx,
                                                  logic signed [SB-1:0] sy);
    stick_result_t r;
    longint x;
    longint y;
    longint unsigned dz;
    longint unsigned sum;
    longint unsigned m;
    longint unsigned s;
    logic sat;
    x = sx;
    y = sy;
    dz = longint'(dz_shadow) << (FB - DZ_W);
    sum = x * x + y * y;
    r = '0;
    if (!pres || sum == 0 || sum < dz * dz) begin
      r.dz_flag = 1'b1;
      return r;
    end
    m = int_sqrt(sum);
    s = ((m - dz) << FB) / (ONE_Q - dz);
    sat = 1'b0;
    r.ox = SB'(clip_axis(x, s, m, sat));
    r.oy = SB'(clip_axis(y, s, m, sat));
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("** radial_stick_deadzone_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    stick_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, out_x, out_y);
        errors <= errors + 1;
      end else begin
        e = expected_q.pop_front();
        if (e.ox !== out_x || e.oy !== out_y || e.dz_flag !== in_deadzone
            || e.sat !== saturated) begin
          $display("%0t: mismatch exp x=%0d y=%0d dz=%b sat=%b got x=%0d y=%0d dz=%b sat=%b",
                   $time, e.ox, e.oy, e.dz_flag, e.sat, out_x, out_y, in_deadzone,
                   saturated);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic send_sample(logic pres, logic signed [SB-1:0] sx, logic signed [SB-1:0] sy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pad_present <= pres;
    stick_x <= sx;
    stick_y <= sy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(rescale_stick(pres, sx, sy));
  endtask

  task automatic write_deadzone(logic [DZ_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    dz_we <= 1'b1;
    dz_wdata <= v;
    @(posedge clk);
    dz_we <= 1'b0;
    dz_shadow = v;
    n_cfg++;
  endtask

  task automatic test_directed();
    logic signed [SB-1:0] ext[6];
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff, 16'sh0148};
    send_sample(1'b0, 16'sh7fff, 16'sh7fff);
    send_sample(1'b1, 16'sh0000, 16'sh0000);
    send_sample(1'b1, 16'sh0cc0, 16'sh0000);
    send_sample(1'b1, 16'sh0ccd, 16'sh0000);
    foreach (ext[i]) send_sample(1'b1, ext[i], ext[(i + 1) % 6]);
    send_sample(1'b1, 16'sh8000, 16'sh8000);
    send_sample(1'b1, 16'sh7fff, 16'sh8000);
    send_sample(1'b1, 16'sh5a82, 16'sh5a82);
    send_sample(1'b1, 16'sha57e, 16'sh5a82);
  endtask

  task automatic test_random(int count);
    logic signed [SB-1:0] sx;
    logic signed [SB-1:0] sy;
    int scale;
    for (int i = 0; i < count; i++) begin
      scale = $urandom_range(3);
      sx = SB'($urandom);
      sy = SB'($urandom);
      if (scale == 0) begin
        sx = sx >>> 10;
        sy = sy >>> 10;
      end else if (scale == 1) begin
        sx = sx >>> 3;
        sy = sy >>> 3;
      end
      send_sample($urandom_range(15) != 0, sx, sy);
    end
  endtask

  task automatic test_deadzone_settings();
    write_deadzone('0);
    test_directed();
    test_random(150);
    write_deadzone(15'h7fff);
    test_directed();
    test_random(150);
    write_deadzone(15'd16384);
    test_random(150);
    write_deadzone(DZ_W'($urandom));
    test_random(150);
    write_deadzone(DZ_RESET);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 34;
    stall_pct = 78;
    test_directed();
    test_random(600);
    send_idle_pct = 78;
    stall_pct = 34;
    test_deadzone_settings();
    send_idle_pct = 0;
    stall_pct = 0;
    test_random(550);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("checked %0d results across %0d deadzone writes", results_seen, n_cfg);
    $display("covered pad absent, zero vector, deadzone edge, full-scale clipping, idle mixes");
    if (errors == 0) begin
      $display("** radial_stick_deadzone_top: PASSED **");
    end else begin
      $display("** radial_stick_deadzone_top: FAILED **");
    end
    $finish;
  end

endmodule
